@@ sv/mba_pkg.sv @@
package mba_pkg;

    // Fixed widths of the transfer fields and of the configuration port.
    localparam int CLASS_W    = 3;
    localparam int FIELD_W    = 48;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;

    localparam logic [FIELD_W-1:0] LIMIT_RESET = FIELD_W'(268435456);

    typedef enum logic [1:0] {
        CMD_RESERVE     = 2'd0,
        CMD_RESERVE_OVR = 2'd1,
        CMD_RELEASE     = 2'd2,
        CMD_QUERY       = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DENIED    = 3'd1,
        ST_BAD_CLASS = 3'd2,
        ST_OVERSIZE  = 3'd3,
        ST_MISMATCH  = 3'd4
    } t_status;

    // Register decode uses the 8-byte slot bit of the address.
    typedef enum logic {
        REG_LIMIT     = 1'b0,
        REG_OUT_CLASS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [FIELD_W-1:0] limit;
        logic [CLASS_W-1:0] out_class;
    } t_cfg;

endpackage

@@ sv/mba_if.sv @@
interface mba_req_if import mba_pkg::*; ();
    logic               valid;
    logic               ready;
    t_cmd               command;
    logic [CLASS_W-1:0] mem_class;
    logic [FIELD_W-1:0] byte_count;
    logic               release_oversized;

    modport source (output valid, command, mem_class, byte_count, release_oversized,
                    input ready);
    modport sink   (input valid, command, mem_class, byte_count, release_oversized,
                    output ready);
endinterface

interface mba_rsp_if import mba_pkg::*; ();
    logic               valid;
    logic               ready;
    t_status            status;
    logic [FIELD_W-1:0] total_used;
    logic [FIELD_W-1:0] class_used;
    logic [FIELD_W-1:0] peak_used;

    modport source (output valid, status, total_used, class_used, peak_used,
                    input ready);
    modport sink   (input valid, status, total_used, class_used, peak_used,
                    output ready);
endinterface

@@ sv/memory_budget_accountant.sv @@
// A transferred request is held in the stage-one registers; its response is then
// registered into the response register and given on the port from there.
// Throughput: one request per cycle, set by the single read-modify-write of the
// per-class memory; a held response stalls the request side.
// Reset (synchronous, active low) clears all counters, oversized mode and the
// per-class valid bits, and loads the limit and output class defaults.
module memory_budget_accountant import mba_pkg::*; #(
    parameter int NUM_CLASSES = 8,
    parameter int BYTE_WIDTH  = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    mba_req_if.sink               i_req,
    mba_rsp_if.source             o_rsp
);

    // Only eight class codes can be presented, so at most eight entries of the
    // per-class memory can ever be touched.
    localparam int CLASS_SPAN = 2 ** CLASS_W;
    localparam int MEM_DEPTH  = (NUM_CLASSES < CLASS_SPAN) ? NUM_CLASSES : CLASS_SPAN;
    localparam int IDX_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int BW         = BYTE_WIDTH;

    t_cfg cfg;

    mba_cfg_regs #(
        .BYTE_WIDTH (BYTE_WIDTH)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // ------------------------------------------------------------------
    // Request stage. On a transfer the class is resolved (an oversized
    // reserve is charged to the configured output class), checked against
    // the number of classes, and the class counter read is issued to the
    // memory. The request itself is held in the stage-one registers.
    // ------------------------------------------------------------------
    logic               req_fire;
    logic               upd_fire;
    logic [CLASS_W-1:0] req_cls;
    logic               req_cls_ok;

    logic               r_s1_vld;
    t_cmd               r_s1_cmd;
    logic               r_s1_ok;
    logic [CLASS_W-1:0] r_s1_cls;
    logic [BW-1:0]      r_s1_bytes;
    logic               r_s1_ovr;

    assign req_cls    = (i_req.command == CMD_RESERVE_OVR) ? cfg.out_class : i_req.mem_class;
    assign req_cls_ok = 7'(req_cls) < 7'(NUM_CLASSES);
    assign req_fire   = i_req.valid && i_req.ready;
    // No request transfer is offered while reset is held.
    assign i_req.ready = i_rst_n && (!r_s1_vld || upd_fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (req_fire) begin
            r_s1_vld <= 1'b1;
        end else if (upd_fire) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_s1_cmd   <= i_req.command;
            r_s1_ok    <= req_cls_ok;
            r_s1_cls   <= req_cls;
            r_s1_bytes <= BW'(i_req.byte_count);
            r_s1_ovr   <= i_req.release_oversized;
        end
    end

    // ------------------------------------------------------------------
    // Per-class counters. The memory forwards its own last write, so a
    // read issued at the edge that writes the same entry still returns
    // the updated count and requests can follow each other every cycle.
    // ------------------------------------------------------------------
    logic [BW-1:0] cls_rd;
    logic [BW-1:0] n_cls;
    logic          cls_wr;

    mba_class_ram #(
        .DEPTH (MEM_DEPTH),
        .WIDTH (BW),
        .IDX_W (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (req_fire && req_cls_ok),
        .i_rd_idx  (IDX_W'(req_cls)),
        .o_rd_data (cls_rd),
        .i_wr_en   (upd_fire && cls_wr),
        .i_wr_idx  (IDX_W'(r_s1_cls)),
        .i_wr_data (n_cls)
    );

    // ------------------------------------------------------------------
    // Update stage. The scalar state (total, peak, oversized mode) lives
    // in registers and is always current here, because the previous
    // request commits at the edge before this one is evaluated.
    // ------------------------------------------------------------------
    logic [BW-1:0] r_total;
    logic [BW-1:0] r_peak;
    logic          r_ovr_act;
    logic [BW-1:0] n_total;
    logic [BW-1:0] n_peak;
    logic          n_ovr_act;
    t_status       n_status;
    logic [BW-1:0] limit;
    logic          over_room;

    assign limit = BW'(cfg.limit);

    // Room left is zero once the limit has been rewritten below the total.
    assign over_room = (r_total >= limit) ? (r_s1_bytes != '0)
                                          : (r_s1_bytes > (limit - r_total));

    always_comb begin
        n_status  = ST_OK;
        n_total   = r_total;
        n_cls     = cls_rd;
        n_ovr_act = r_ovr_act;
        cls_wr    = 1'b0;
        if (!r_s1_ok) begin
            n_status = ST_BAD_CLASS;
        end else begin
            unique case (r_s1_cmd)
                CMD_RESERVE: begin
                    if (r_ovr_act || over_room) begin
                        n_status = ST_DENIED;
                    end else begin
                        n_total = r_total + r_s1_bytes;
                        n_cls   = cls_rd + r_s1_bytes;
                        cls_wr  = 1'b1;
                    end
                end
                CMD_RESERVE_OVR: begin
                    // The oversized reserve is only taken from an empty budget.
                    if ((r_s1_bytes <= limit) || (r_total != '0) || r_ovr_act) begin
                        n_status = ST_OVERSIZE;
                    end else begin
                        n_total   = r_s1_bytes;
                        n_cls     = r_s1_bytes;
                        n_ovr_act = 1'b1;
                        cls_wr    = 1'b1;
                    end
                end
                CMD_RELEASE: begin
                    if ((r_total < r_s1_bytes) || (cls_rd < r_s1_bytes) ||
                        (r_s1_ovr && !r_ovr_act) ||
                        (r_s1_ovr && (r_total != r_s1_bytes))) begin
                        n_status = ST_MISMATCH;
                    end else begin
                        n_total = r_total - r_s1_bytes;
                        n_cls   = cls_rd - r_s1_bytes;
                        cls_wr  = 1'b1;
                        if (r_s1_ovr) begin
                            n_ovr_act = 1'b0;
                        end
                    end
                end
                CMD_QUERY: begin
                    n_status = ST_OK;
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
        // The peak follows the new total, so the total never exceeds the peak.
        n_peak = (n_total > r_peak) ? n_total : r_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_peak    <= '0;
            r_ovr_act <= 1'b0;
        end else if (upd_fire) begin
            r_total   <= n_total;
            r_peak    <= n_peak;
            r_ovr_act <= n_ovr_act;
        end
    end

    // ------------------------------------------------------------------
    // Response register. It frees the update stage as soon as the waiting
    // response is taken, in the same cycle, so a stalled sink costs no
    // bubble once it resumes.
    // ------------------------------------------------------------------
    logic               r_out_vld;
    t_status            r_out_status;
    logic [FIELD_W-1:0] r_out_total;
    logic [FIELD_W-1:0] r_out_class;
    logic [FIELD_W-1:0] r_out_peak;

    assign upd_fire = r_s1_vld && (!r_out_vld || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (upd_fire) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_fire) begin
            r_out_status <= n_status;
            r_out_total  <= FIELD_W'(n_total);
            r_out_class  <= r_s1_ok ? FIELD_W'(n_cls) : '0;
            r_out_peak   <= FIELD_W'(n_peak);
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.total_used = r_out_total;
    assign o_rsp.class_used = r_out_class;
    assign o_rsp.peak_used  = r_out_peak;

endmodule

@@ sv/mba_cfg_regs.sv @@
module mba_cfg_regs import mba_pkg::*; #(
    parameter int BYTE_WIDTH = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    // The limit keeps only as many bits as the byte counters carry.
    localparam int                 MASK_W     = (BYTE_WIDTH < FIELD_W) ? BYTE_WIDTH : FIELD_W;
    localparam logic [FIELD_W-1:0] LIMIT_MASK = {FIELD_W{1'b1}} >> (FIELD_W - MASK_W);

    t_cfg     r_cfg;
    t_reg_idx reg_sel;
    logic     wr_en;

    assign reg_sel = t_reg_idx'(paddr[3]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.limit     <= LIMIT_RESET & LIMIT_MASK;
            r_cfg.out_class <= '0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_LIMIT:     r_cfg.limit     <= pwdata[FIELD_W-1:0] & LIMIT_MASK;
                REG_OUT_CLASS: r_cfg.out_class <= pwdata[CLASS_W-1:0];
                default:       r_cfg.limit     <= r_cfg.limit;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_LIMIT:     prdata = APB_DATA_W'(r_cfg.limit);
            REG_OUT_CLASS: prdata = APB_DATA_W'(r_cfg.out_class);
            default:       prdata = '0;
        endcase
    end

endmodule

@@ sv/mba_class_ram.sv @@
module mba_class_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 48,
    parameter int IDX_W = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_idx,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_vld;
    logic [DEPTH-1:0] r_vld;
    logic             r_lw_vld;
    logic [IDX_W-1:0] r_lw_idx;
    logic [WIDTH-1:0] r_lw_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_idx];
            r_rd_idx  <= i_rd_idx;
        end
        if (i_wr_en) begin
            r_lw_idx  <= i_wr_idx;
            r_lw_data <= i_wr_data;
        end
    end

    // Entries never written read as zero; the last write is kept so that a
    // read issued in the same cycle as a write to that entry sees new data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_lw_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_idx] <= 1'b1;
                r_lw_vld        <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_idx];
            end
        end
    end

    always_comb begin
        if (r_lw_vld && (r_lw_idx == r_rd_idx)) begin
            o_rd_data = r_lw_data;
        end else if (r_rd_vld) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule
